// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// checked on every edge
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// ===== hw/rtl/ngga_pkg.sv =====
// ----------------------------------------------------------------------------
// ngga_pkg
// Types, character codes and per-field tables of the GGA sentence parser.
// ----------------------------------------------------------------------------
package ngga_pkg;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_POINT  = 8'h2E;

   localparam logic [31:0] ACC_CAP  = 32'd4000000000;
   localparam logic [17:0] TIME_CAP = 18'd235959;

   localparam int TAG_LEN = 5;

   localparam int RSP_DATA_W = 176;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_TIME,
      KIND_HEMI,
      KIND_NUM
   } kind_type;

   typedef logic signed [33:0] wide_type;

   function automatic logic [7:0] tag_char(input logic [2:0] i);
      logic [7:0] r;
      unique case (i)
         3'd0:    r = 8'h47;
         3'd1:    r = 8'h50;
         3'd2:    r = 8'h47;
         3'd3:    r = 8'h47;
         default: r = 8'h41;
      endcase
      return r;
   endfunction

   function automatic kind_type field_kind(input logic [4:0] fi);
      kind_type k;
      unique case (fi)
         5'd1:                            k = KIND_TIME;
         5'd3, 5'd5:                      k = KIND_HEMI;
         5'd2, 5'd4, 5'd6, 5'd7, 5'd8,
         5'd9, 5'd11:                     k = KIND_NUM;
         default:                         k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] field_dec(input logic [4:0] fi);
      logic [2:0] d;
      unique case (fi)
         5'd2, 5'd4:          d = 3'd5;
         5'd8, 5'd9, 5'd11:   d = 3'd2;
         default:             d = 3'd0;
      endcase
      return d;
   endfunction

   function automatic wide_type field_lo(input logic [4:0] fi);
      wide_type v;
      unique case (fi)
         5'd9:    v = -34'sd9999999;
         5'd11:   v = -34'sd999999;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   function automatic wide_type field_hi(input logic [4:0] fi);
      wide_type v;
      unique case (fi)
         5'd2:    v = 34'sd999999999;
         5'd4:    v = 34'sd1999999999;
         5'd6:    v = 34'sd9;
         5'd7:    v = 34'sd99;
         5'd8:    v = 34'sd9999;
         5'd9:    v = 34'sd99999999;
         default: v = 34'sd999999;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] pow10(input logic [2:0] k);
      logic [16:0] p;
      unique case (k)
         3'd0:    p = 17'd1;
         3'd1:    p = 17'd10;
         3'd2:    p = 17'd100;
         3'd3:    p = 17'd1000;
         3'd4:    p = 17'd10000;
         default: p = 17'd100000;
      endcase
      return p;
   endfunction

   function automatic logic [31:0] acc_push(input logic [31:0] acc, input logic [3:0] d);
      logic [35:0] v;
      v = {acc, 3'b000} + {3'b000, acc, 1'b0} + 36'(d);
      return (v > 36'(ACC_CAP)) ? ACC_CAP : v[31:0];
   endfunction

endpackage

// ===== hw/rtl/nmea_gga_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// Parses GGA sentences from a received character stream into fixed point.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle unless a waiting result holds back a
// closing '$'; each character is handled combinationally between the state
// registers and the result register. A result word for a GPGGA sentence is
// valid in the cycle after the '$' that opens the next sentence is accepted.
// While a result waits, characters other than a closing '$' are still accepted.
module nmea_gga_sentence_parser
   import ngga_pkg::*;
#(
   parameter int MAX_BODY_LEN = 255,
   parameter int MAX_FIELDS   = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // time_hhmmss, latitude, lat_hemisphere, longitude, lon_hemisphere,
   // fix_quality, satellites, hdop, altitude, geoid_height, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser    // checksum_ok
);

   localparam int FI_W = $clog2(MAX_FIELDS + 1);
   localparam int BL_W = $clog2(MAX_BODY_LEN + 1);

   typedef enum logic [1:0] {ST_HUNT, ST_TAG, ST_BODY} phase_type;

   phase_type         phase_ff, phase_in;
   logic [2:0]        tag_cnt_ff, tag_cnt_in;
   logic [FI_W-1:0]   fi_ff, fi_in;
   logic [4:0]        pos_ff, pos_in;
   logic [7:0]        xor_ff, xor_in;
   logic              star_ff, star_in;
   logic [7:0]        sent_ff, sent_in;
   logic [1:0]        hex_ff, hex_in;
   logic [BL_W-1:0]   blen_ff, blen_in;
   logic [31:0]       acc_ff, acc_in;
   logic [2:0]        frac_ff, frac_in;
   logic              point_ff, point_in;
   logic              neg_ff, neg_in;
   logic              stop_ff, stop_in;
   logic [2:0]        tstop_ff, tstop_in;
   logic [6:0]        tpart_ff [3];
   logic [6:0]        tpart_in [3];

   logic [17:0]       time_ff, time_in;
   logic [29:0]       lat_ff, lat_in;
   logic [7:0]        lath_ff, lath_in;
   logic [30:0]       lon_ff, lon_in;
   logic [7:0]        lonh_ff, lonh_in;
   logic [3:0]        fix_ff, fix_in;
   logic [6:0]        sats_ff, sats_in;
   logic [13:0]       hdop_ff, hdop_in;
   logic [27:0]       alt_ff, alt_in;
   logic [20:0]       geoid_ff, geoid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_ok_ff, rsp_ok_in;

   logic [7:0]        c;
   logic              accept, emit_req, emit, fin, clr_field, start;
   logic [4:0]        fi5;
   kind_type          kind;
   logic [2:0]        dec;
   logic              dig, hexv;
   logic [3:0]        dval, hval;
   logic [1:0]        tp;
   logic [48:0]       prod;
   logic [31:0]       scaled;
   wide_type          sval, cval;
   logic [19:0]       tsum;
   logic [17:0]       tval;

   assign c        = req_tdata;
   assign emit_req = (phase_ff == ST_BODY) && (c == CH_DOLLAR);
   assign req_tready = !rsp_valid_ff || rsp_tready || !emit_req;
   assign accept   = req_tvalid && req_tready;
   assign fi5      = 5'(fi_ff);
   assign kind     = field_kind(fi5);
   assign dec      = field_dec(fi5);
   assign dig      = (c >= 8'h30) && (c <= 8'h39);
   assign dval     = c[3:0];
   assign tp       = pos_ff[2:1];

   always_comb begin
      hexv = 1'b1;
      hval = c[3:0];
      if (dig) begin
         hval = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         hval = 4'(c[2:0] + 3'd1) + 4'd8;
      end else begin
         hexv = 1'b0;
      end
   end

   // field finish values
   assign prod   = 49'(acc_ff) * 49'(pow10(dec - frac_ff));
   assign scaled = (prod > 49'(ACC_CAP)) ? ACC_CAP : prod[31:0];
   assign sval   = neg_ff ? -wide_type'({2'b00, scaled}) : wide_type'({2'b00, scaled});
   always_comb begin
      cval = sval;
      if (sval < field_lo(fi5)) cval = field_lo(fi5);
      if (sval > field_hi(fi5)) cval = field_hi(fi5);
   end
   assign tsum = 20'(tpart_ff[0]) * 20'd10000 + 20'(tpart_ff[1]) * 20'd100
               + 20'(tpart_ff[2]);
   assign tval = (tsum > 20'(TIME_CAP)) ? TIME_CAP : tsum[17:0];

   always_comb begin
      phase_in = phase_ff;  tag_cnt_in = tag_cnt_ff; fi_in = fi_ff;
      pos_in = pos_ff;      xor_in = xor_ff;        star_in = star_ff;
      sent_in = sent_ff;    hex_in = hex_ff;        blen_in = blen_ff;
      acc_in = acc_ff;      frac_in = frac_ff;      point_in = point_ff;
      neg_in = neg_ff;      stop_in = stop_ff;      tstop_in = tstop_ff;
      tpart_in = tpart_ff;
      time_in = time_ff;    lat_in = lat_ff;        lath_in = lath_ff;
      lon_in = lon_ff;      lonh_in = lonh_ff;      fix_in = fix_ff;
      sats_in = sats_ff;    hdop_in = hdop_ff;      alt_in = alt_ff;
      geoid_in = geoid_ff;
      emit = 1'b0; fin = 1'b0; clr_field = 1'b0; start = 1'b0;

      if (accept) begin
         if (emit_req) begin
            emit  = 1'b1;
            fin   = !star_ff;
            start = 1'b1;
         end else if (c == CH_DOLLAR) begin
            start = 1'b1;
         end else begin
            unique case (phase_ff)
               ST_HUNT: begin
               end
               ST_TAG: begin
                  if (tag_cnt_ff < 3'(TAG_LEN) && c == tag_char(tag_cnt_ff)) begin
                     xor_in     = xor_ff ^ c;
                     tag_cnt_in = tag_cnt_ff + 3'd1;
                     if (tag_cnt_ff == 3'(TAG_LEN - 1)) phase_in = ST_BODY;
                  end else begin
                     phase_in = ST_HUNT;
                  end
               end
               default: begin
                  if (blen_ff >= BL_W'(MAX_BODY_LEN)) begin
                     phase_in = ST_HUNT;
                  end else begin
                     blen_in = blen_ff + 1'b1;
                     if (star_ff) begin
                        if (hex_ff < 2'd2) begin
                           if (hexv) begin
                              sent_in = {sent_ff[3:0], hval};
                              hex_in  = hex_ff + 2'd1;
                           end else begin
                              hex_in = 2'd3;
                           end
                        end
                     end else if (c == CH_STAR) begin
                        fin     = 1'b1;
                        star_in = 1'b1;
                     end else begin
                        xor_in = xor_ff ^ c;
                        if (c == CH_COMMA) begin
                           fin = 1'b1;
                           if (fi_ff < FI_W'(MAX_FIELDS)) fi_in = fi_ff + 1'b1;
                           clr_field = 1'b1;
                        end else begin
                           if (pos_ff < 5'd31) pos_in = pos_ff + 5'd1;
                           unique case (kind)
                              KIND_HEMI: begin
                                 if (pos_ff == 5'd0) begin
                                    if (fi5 == 5'd3) lath_in = c;
                                    else lonh_in = c;
                                 end
                              end
                              KIND_TIME: begin
                                 if (pos_ff < 5'd6 && !tstop_ff[tp]) begin
                                    if (dig) tpart_in[tp] = 7'(tpart_ff[tp] * 7'd10 + 7'(dval));
                                    else tstop_in[tp] = 1'b1;
                                 end
                              end
                              KIND_NUM: begin
                                 if (!stop_ff) begin
                                    if (pos_ff == 5'd0 && (c == CH_MINUS || c == CH_PLUS)) begin
                                       neg_in = (c == CH_MINUS);
                                    end else if (dig) begin
                                       if (!point_ff) begin
                                          acc_in = acc_push(acc_ff, dval);
                                       end else if (frac_ff < dec) begin
                                          acc_in  = acc_push(acc_ff, dval);
                                          frac_in = frac_ff + 3'd1;
                                       end
                                    end else if (c == CH_POINT && !point_ff) begin
                                       point_in = 1'b1;
                                    end else begin
                                       stop_in = 1'b1;
                                    end
                                 end
                              end
                              default: begin
                              end
                           endcase
                        end
                     end
                  end
               end
            endcase
         end
      end

      if (fin) begin
         unique case (fi5)
            5'd1:    time_in  = tval;
            5'd2:    lat_in   = cval[29:0];
            5'd4:    lon_in   = cval[30:0];
            5'd6:    fix_in   = cval[3:0];
            5'd7:    sats_in  = cval[6:0];
            5'd8:    hdop_in  = cval[13:0];
            5'd9:    alt_in   = cval[27:0];
            5'd11:   geoid_in = cval[20:0];
            default: begin
            end
         endcase
      end

      rsp_data_in = {7'd0, geoid_in, alt_in, hdop_in, sats_in, fix_in, lonh_in,
                     lon_in, lath_in, lat_in, time_in};
      rsp_ok_in   = star_ff && (sent_ff == xor_ff);

      if (start) begin
         phase_in = ST_TAG; tag_cnt_in = 3'd0; fi_in = '0; xor_in = 8'd0;
         star_in = 1'b0;    sent_in = 8'd0;    hex_in = 2'd0; blen_in = '0;
         time_in = '0; lat_in = '0; lath_in = '0; lon_in = '0; lonh_in = '0;
         fix_in = '0;  sats_in = '0; hdop_in = '0; alt_in = '0; geoid_in = '0;
      end
      if (start || clr_field) begin
         pos_in = 5'd0; acc_in = 32'd0; frac_in = 3'd0; point_in = 1'b0;
         neg_in = 1'b0; stop_in = 1'b0; tstop_in = 3'd0;
         tpart_in[0] = 7'd0; tpart_in[1] = 7'd0; tpart_in[2] = 7'd0;
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_HUNT; tag_cnt_ff <= 3'd0; fi_ff <= '0; pos_ff <= 5'd0;
         xor_ff <= 8'd0; star_ff <= 1'b0; sent_ff <= 8'd0; hex_ff <= 2'd0;
         blen_ff <= '0; acc_ff <= 32'd0; frac_ff <= 3'd0; point_ff <= 1'b0;
         neg_ff <= 1'b0; stop_ff <= 1'b0; tstop_ff <= 3'd0;
         tpart_ff[0] <= 7'd0; tpart_ff[1] <= 7'd0; tpart_ff[2] <= 7'd0;
         time_ff <= '0; lat_ff <= '0; lath_ff <= '0; lon_ff <= '0; lonh_ff <= '0;
         fix_ff <= '0; sats_ff <= '0; hdop_ff <= '0; alt_ff <= '0; geoid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; tag_cnt_ff <= tag_cnt_in; fi_ff <= fi_in;
         pos_ff <= pos_in; xor_ff <= xor_in; star_ff <= star_in;
         sent_ff <= sent_in; hex_ff <= hex_in; blen_ff <= blen_in;
         acc_ff <= acc_in; frac_ff <= frac_in; point_ff <= point_in;
         neg_ff <= neg_in; stop_ff <= stop_in; tstop_ff <= tstop_in;
         tpart_ff <= tpart_in;
         time_ff <= time_in; lat_ff <= lat_in; lath_ff <= lath_in;
         lon_ff <= lon_in; lonh_ff <= lonh_in; fix_ff <= fix_in;
         sats_ff <= sats_in; hdop_ff <= hdop_in; alt_ff <= alt_in;
         geoid_ff <= geoid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ok_ff   <= rsp_ok_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

// ===== hw/rtl/ngga_checker.sv =====
// ----------------------------------------------------------------------------
// ngga_checker
// Port-level checks of the GGA sentence parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ngga_checker
   import ngga_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [7:0]            req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   `CHK_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid)

   `CHK_ASSERT(a_word_after_dollar, clock, reset,
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tdata == CH_DOLLAR))

   `CHK_ASSERT(a_fields_in_range, clock, reset,
      rsp_tvalid |-> (rsp_tdata[17:0] <= TIME_CAP && rsp_tdata[98:95] <= 4'd9))

   `CHK_ASSERT(a_stalled_word_holds, clock, reset,
      $past(rsp_tvalid && !rsp_tready) |-> ($stable(rsp_tdata) && $stable(rsp_tuser)))

endmodule

bind nmea_gga_sentence_parser ngga_checker u_ngga_checker (.*);

// ===== sim/nmea_gga_sentence_parser_tb.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser_tb
// Feeds GGA sentences, broken tags and line noise into the parser one byte per
// word. A local model of the parser predicts each result word, and the
// monitor checks every returned field against it under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_gga_sentence_parser_tb;
   import ngga_pkg::*;

   localparam int BODY_MAX   = 255;
   localparam int FIELDS_MAX = 15;
   localparam int WD_LIMIT   = 5000;
   localparam int LONG_HOLD  = 400;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef enum logic [1:0] {PH_HUNT, PH_TAG, PH_BODY} phase_type;

   typedef struct packed {
      logic                  ok;
      logic [RSP_DATA_W-1:0] data;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   nmea_gga_sentence_parser dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   // parser model state
   phase_type   ph = PH_HUNT;
   int unsigned tag_cnt, fld, pos_in_fld, xsum, star_seen, sent_sum, hex_cnt, body_len;
   logic [31:0] acc;
   int unsigned frac_cnt, point_seen, is_neg, num_done, time_stop;
   int unsigned tpart [3];
   logic [31:0] rf [11];

   logic [7:0]  tx_bytes [$];
   reading_type readings_due [$];
   int          fw [11] = '{1, 18, 30, 8, 31, 8, 4, 7, 14, 28, 21};
   int          mismatches = 0;
   int          results_seen = 0;
   int          sentences = 0;

   function automatic void fld_desc(input int unsigned fi, output kind_type k,
         output int slot, output int dec, output longint lo, output longint hi);
      k = KIND_NONE; slot = 0; dec = 0; lo = 0; hi = 0;
      case (fi)
         1:  begin k = KIND_TIME; slot = 1; hi = 235959; end
         2:  begin k = KIND_NUM; slot = 2; dec = 5; hi = 999999999; end
         3:  begin k = KIND_HEMI; slot = 3; end
         4:  begin k = KIND_NUM; slot = 4; dec = 5; hi = 1999999999; end
         5:  begin k = KIND_HEMI; slot = 5; end
         6:  begin k = KIND_NUM; slot = 6; hi = 9; end
         7:  begin k = KIND_NUM; slot = 7; hi = 99; end
         8:  begin k = KIND_NUM; slot = 8; dec = 2; hi = 9999; end
         9:  begin k = KIND_NUM; slot = 9; dec = 2; lo = -9999999; hi = 99999999; end
         11: begin k = KIND_NUM; slot = 10; dec = 2; lo = -999999; hi = 999999; end
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] times10(input logic [31:0] a, input int unsigned d);
      longint unsigned v;
      v = longint'(a) * 10 + d;
      return (v > 64'd4000000000) ? 32'd4000000000 : v[31:0];
   endfunction

   function automatic void clear_fld();
      pos_in_fld = 0; acc = 0; frac_cnt = 0; point_seen = 0; is_neg = 0;
      num_done = 0; time_stop = 0; tpart[0] = 0; tpart[1] = 0; tpart[2] = 0;
   endfunction

   function automatic void open_sentence();
      ph = PH_TAG; tag_cnt = 0; fld = 0; xsum = 0; star_seen = 0; sent_sum = 0;
      hex_cnt = 0; body_len = 0;
      for (int j = 0; j < 11; j++) rf[j] = 0;
      clear_fld();
   endfunction

   function automatic void close_fld();
      kind_type k;
      int slot, dec;
      longint lo, hi, v;
      int unsigned t;
      logic [31:0] a;
      if (fld >= 12) return;
      fld_desc(fld, k, slot, dec, lo, hi);
      if (k == KIND_TIME) begin
         t = tpart[0] * 10000 + tpart[1] * 100 + tpart[2];
         rf[slot] = (t > 235959) ? 235959 : t;
      end else if (k == KIND_NUM) begin
         a = acc;
         for (int i = frac_cnt; i < dec; i++) a = times10(a, 0);
         v = is_neg ? -longint'(a) : longint'(a);
         if (v < lo) v = lo;
         if (v > hi) v = hi;
         rf[slot] = v[31:0];
      end
   endfunction

   function automatic void fld_char(input logic [7:0] c);
      kind_type k;
      int slot, dec;
      longint lo, hi;
      int unsigned p, pr;
      bit dig;
      p = pos_in_fld;
      if (pos_in_fld < 31) pos_in_fld++;
      if (fld >= 12) return;
      fld_desc(fld, k, slot, dec, lo, hi);
      dig = (c >= "0" && c <= "9");
      if (k == KIND_HEMI) begin
         if (p == 0) rf[slot] = c;
      end else if (k == KIND_TIME) begin
         if (p < 6) begin
            pr = p >> 1;
            if (!time_stop[pr]) begin
               if (dig) tpart[pr] = tpart[pr] * 10 + (c - "0");
               else time_stop |= 1 << pr;
            end
         end
      end else if (k == KIND_NUM && !num_done) begin
         if (p == 0 && (c == CH_MINUS || c == CH_PLUS)) is_neg = (c == CH_MINUS);
         else if (dig) begin
            if (!point_seen) acc = times10(acc, c - "0");
            else if (frac_cnt < dec) begin
               acc = times10(acc, c - "0");
               frac_cnt++;
            end
         end else if (c == CH_POINT && !point_seen) point_seen = 1;
         else num_done = 1;
      end
   endfunction

   function automatic int hexval(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   // advances the model by one byte, queues a reading when a sentence closes
   function automatic void parse_byte(input logic [7:0] c);
      reading_type r;
      int off, h;
      if (ph == PH_BODY && c == CH_DOLLAR) begin
         if (!star_seen) close_fld();
         r.ok = star_seen && (sent_sum == xsum);
         r.data = '0;
         off = 0;
         for (int j = 1; j < 11; j++) begin
            for (int b = 0; b < fw[j]; b++) r.data[off + b] = rf[j][b];
            off += fw[j];
         end
         readings_due.push_back(r);
         open_sentence();
         return;
      end
      if (c == CH_DOLLAR) begin
         open_sentence();
         return;
      end
      if (ph == PH_HUNT) return;
      if (ph == PH_TAG) begin
         if (tag_cnt < 5 && c == tag_char(3'(tag_cnt))) begin
            xsum ^= c;
            tag_cnt++;
            if (tag_cnt == 5) ph = PH_BODY;
         end else ph = PH_HUNT;
         return;
      end
      if (body_len >= BODY_MAX) begin
         ph = PH_HUNT;
         return;
      end
      body_len++;
      if (star_seen) begin
         if (hex_cnt < 2) begin
            h = hexval(c);
            if (h < 0) hex_cnt = 3;
            else begin
               sent_sum = ((sent_sum << 4) | h) & 8'hFF;
               hex_cnt++;
            end
         end
         return;
      end
      if (c == CH_STAR) begin
         close_fld();
         star_seen = 1;
         return;
      end
      xsum ^= c;
      if (c == CH_COMMA) begin
         close_fld();
         if (fld < FIELDS_MAX) fld++;
         clear_fld();
      end else fld_char(c);
   endfunction

   function automatic logic [31:0] field_of(input reading_type r, input int j);
      logic [31:0] v;
      int off;
      v = 0;
      off = 0;
      if (j == 0) return r.ok;
      for (int i = 1; i < j; i++) off += fw[i];
      for (int b = 0; b < fw[j]; b++) v[b] = r.data[off + b];
      return v;
   endfunction

   // stimulus builders
   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
   endtask

   function automatic string digits(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      return s;
   endfunction

   function automatic string rand_num();
      string s;
      s = "";
      case ($urandom_range(0, 5))
         0: s = "-";
         1: s = "+";
         default: ;
      endcase
      s = {s, digits($urandom_range(0, ($urandom_range(0, 5) == 0) ? 14 : 5))};
      if ($urandom_range(0, 2) != 0) s = {s, ".", digits($urandom_range(0, 8))};
      if ($urandom_range(0, 9) == 0) s = {s, ($urandom_range(0, 1) ? "." : "x"), digits(2)};
      return s;
   endfunction

   function automatic string rand_field(input int i);
      string s;
      if ($urandom_range(0, 9) == 0) return "";
      case (i)
         1: begin
            s = digits(6);
            if ($urandom_range(0, 4) == 0)
               s[$urandom_range(0, 5)] = byte'(8'h41 + 8'($urandom_range(0, 25)));
            if ($urandom_range(0, 1)) s = {s, ".", digits(2)};
            return s;
         end
         3: return $urandom_range(0, 5) == 0 ? $sformatf("%c", $urandom_range(33, 126))
                                             : ($urandom_range(0, 1) ? "N" : "S");
         5: return $urandom_range(0, 5) == 0 ? $sformatf("%c%c", $urandom_range(33, 126), "Q")
                                             : ($urandom_range(0, 1) ? "E" : "W");
         10, 12: return "M";
         default: return rand_num();
      endcase
   endfunction

   // one sentence from "$GPGGA" through the line end, closing '$' not included
   task automatic push_sentence(input string body, input int form);
      int unsigned x;
      x = 0;
      for (int i = 0; i < body.len(); i++) x ^= body[i];
      case (form)
         0: push_str({"$", body, $sformatf("*%02X", x)});
         1: push_str({"$", body, $sformatf("*%02x", x)});
         2: push_str({"$", body, $sformatf("*%02X", x ^ (1 << $urandom_range(0, 7)))});
         3: push_str({"$", body});
         default: push_str({"$", body, "*", $sformatf("%c", $urandom_range(33, 126))});
      endcase
      tx_bytes.push_back(CH_CR);
      tx_bytes.push_back(CH_LF);
      sentences++;
   endtask

   task automatic rand_sentence();
      string b;
      int n, star_at;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : 14;
      star_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 14) : 99;
      b = "GPGGA";
      for (int i = 1; i <= n; i++) begin
         b = {b, ",", rand_field(i)};
         if (i == star_at) b = {b, "*", digits(2)};
      end
      push_sentence(b, ($urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 4));
   endtask

   // driver
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) parse_byte(req_tdata);
         if (gap > 0) begin
            gap <= gap - 1;
            req_tvalid <= 1'b0;
         end else if (tx_bytes.size() > 0) begin
            req_tdata <= tx_bytes.pop_front();
            req_tvalid <= 1'b1;
            if (tx_bytes.size() > 200 && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   int  stall = 0;
   bit  long_done = 0;
   always @(posedge clock) begin
      reading_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.ok = rsp_tuser;
            got.data = rsp_tdata;
            if (readings_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word: %h %h", got.ok, got.data);
            end else begin
               want = readings_due.pop_front();
               for (int j = 0; j < 11; j++) begin
                  if (field_of(got, j) !== field_of(want, j)) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display("field %0d mismatch: expected %h actual %h",
                                 j, field_of(want, j), field_of(got, j));
                  end
               end
            end
         end
         if (!long_done && results_seen == 8) begin
            long_done = 1;
            stall <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else if (tx_bytes.size() > 200 && $urandom_range(0, 7) == 0) begin
            stall <= $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      string b;
      string tag_s;
      tag_s = "GPGGA";
      // directed sentences
      push_sentence("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 0);
      push_sentence("GPGGA,999999,99999.9999999,S,999999.999999,W,15,999,999.999,"
                    , 1);
      push_str("99999999999.99,M,-99999999.99,M,,");
      push_sentence("GPGGA,235959,0.00001,N,-1,E,-3,-5,-2,-999999999,M,-99999999,M,,", 0);
      push_sentence("GPGGA,,,,,,,,,,,,,,", 0);
      push_sentence("GPGGA,12a4x6,12.3.4,,+7.5e3,,+9,1x,.5,-.25,M,+.999,M", 3);
      push_sentence("GPGGA,000000,1*3F,2,3", 2);
      push_sentence("GPGGA,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,21", 0);
      push_str("$GPGSA,1,2*00$GP$GX$$GPG");
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'hFF);
      b = "GPGGA,";
      for (int i = 0; i < 260; i++) b = {b, "7"};
      push_sentence(b, 0);
      push_sentence("GPGGA,010203,,,,,1,,,,,,,,", 4);
      // random part
      while (tx_bytes.size() < 1900 || sentences < 45) begin
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 8)) tx_bytes.push_back(8'($urandom_range(0, 255)));
            1: push_str({"$", tag_s.substr(0, $urandom_range(0, 4)),
                         $sformatf("%c", $urandom_range(33, 126)), ",12"});
            default: rand_sentence();
         endcase
      end
      tx_bytes.push_back(CH_DOLLAR);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (tx_bytes.size() > 0 || req_tvalid || readings_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && readings_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
